// ----- rtl/core/b64da_pkg.sv -----
package b64da_pkg;

  // fixed widths of the interface fields
  localparam int VALUE_W = 64;
  localparam int CHAR_W = 6;
  localparam int MAX_DIGITS = 20;

  // input bits folded into the bcd register per conversion cycle
  localparam int BITS_PER_STEP = 4;
  localparam int CONV_STEPS = VALUE_W / BITS_PER_STEP;
  localparam int STEP_CNT_W = $clog2(CONV_STEPS);

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_SKIP,
    S_EMIT
  } state_t;

  // double dabble correction: a digit of five or more gets three added before the shift
  function automatic logic [3:0] add3(input logic [3:0] d);
    return (d >= 4'd5) ? d + 4'd3 : d;
  endfunction

endpackage

// ----- rtl/core/b64da_bcd_step.sv -----
module b64da_bcd_step #(
  parameter int NUM_DIGITS = b64da_pkg::MAX_DIGITS
) (
  input  logic [NUM_DIGITS-1:0][3:0]            bcd_in,
  input  logic [b64da_pkg::BITS_PER_STEP-1:0]   bits_in,
  output logic [NUM_DIGITS-1:0][3:0]            bcd_out
);

  localparam int FLAT_W = 4 * NUM_DIGITS;

  logic [FLAT_W-1:0] work;

  // one shift-and-correct pass per input bit, msb first
  always_comb begin
    work = bcd_in;
    for (int s = b64da_pkg::BITS_PER_STEP - 1; s >= 0; s--) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        work[4*d +: 4] = b64da_pkg::add3(work[4*d +: 4]);
      end
      work = {work[FLAT_W-2:0], bits_in[s]};
    end
    bcd_out = work;
  end

endmodule

// ----- rtl/core/binary64_to_decimal_ascii.sv -----
// Converts one unsigned 64-bit value per input transfer into its decimal text,
// one ASCII digit per output transfer, most significant first, no leading
// zeros; zero gives a single '0'. last_digit marks the final (units) digit.
// The value is turned into BCD by a shared double dabble step that folds in
// four input bits a cycle. Leading zero digits are then skipped at one per
// cycle starting from the top digit, and the digits are sent one per cycle
// while out_ready is high. in_ready is high only while the block is idle.
module binary64_to_decimal_ascii #(
  parameter int MAX_DIGITS = b64da_pkg::MAX_DIGITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [b64da_pkg::VALUE_W-1:0]   value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [b64da_pkg::CHAR_W-1:0]    digit_char,
  output logic                            last_digit
);

  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam int VW = b64da_pkg::VALUE_W;
  localparam int BPS = b64da_pkg::BITS_PER_STEP;

  b64da_pkg::state_t state, state_next;

  // value bits still to be folded in, msb first
  logic [VW-1:0]                      shreg;
  // bcd digits, digit 0 is the units digit
  logic [MAX_DIGITS-1:0][3:0]         bcd;
  logic [MAX_DIGITS-1:0][3:0]         bcd_next;
  logic [b64da_pkg::STEP_CNT_W-1:0]   step_cnt;
  // digit currently being skipped or sent
  logic [IDX_W-1:0]                   idx;

  logic [3:0] cur_digit;
  logic       in_xfer;
  logic       out_xfer;
  logic       conv_done;
  logic       at_units;
  logic       skip_more;

  assign cur_digit = bcd[idx];
  assign at_units  = (idx == IDX_W'(0));
  assign conv_done = (step_cnt == b64da_pkg::STEP_CNT_W'(b64da_pkg::CONV_STEPS - 1));
  // a zero digit above the units place is a leading zero
  assign skip_more = (cur_digit == 4'd0) && !at_units;
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;

  // shared shift-and-add-3 unit
  b64da_bcd_step #(
    .NUM_DIGITS(MAX_DIGITS)
  ) u_step (
    .bcd_in  (bcd),
    .bits_in (shreg[VW-1 -: BPS]),
    .bcd_out (bcd_next)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      b64da_pkg::S_IDLE: begin
        if (in_xfer) state_next = b64da_pkg::S_CONV;
      end
      b64da_pkg::S_CONV: begin
        if (conv_done) state_next = b64da_pkg::S_SKIP;
      end
      b64da_pkg::S_SKIP: begin
        if (!skip_more) state_next = b64da_pkg::S_EMIT;
      end
      b64da_pkg::S_EMIT: begin
        if (out_xfer && at_units) state_next = b64da_pkg::S_IDLE;
      end
      default: state_next = b64da_pkg::S_IDLE;
    endcase
  end

  // outputs, payload comes straight from registers held while stalled
  always_comb begin
    in_ready   = (state == b64da_pkg::S_IDLE);
    out_valid  = (state == b64da_pkg::S_EMIT);
    digit_char = b64da_pkg::ASCII_ZERO + {2'b00, cur_digit};
    last_digit = at_units;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= b64da_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      b64da_pkg::S_IDLE: begin
        if (in_xfer) begin
          shreg    <= value;
          bcd      <= '0;
          step_cnt <= '0;
        end
      end
      b64da_pkg::S_CONV: begin
        bcd      <= bcd_next;
        shreg    <= {shreg[VW-BPS-1:0], {BPS{1'b0}}};
        step_cnt <= step_cnt + 1'b1;
        idx      <= IDX_W'(MAX_DIGITS - 1);
      end
      b64da_pkg::S_SKIP: begin
        if (skip_more) idx <= idx - 1'b1;
      end
      b64da_pkg::S_EMIT: begin
        if (out_xfer && !at_units) idx <= idx - 1'b1;
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  // never taking input while a digit is offered
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("in_ready and out_valid high together");

  // conversion always takes cycles before the first digit
  a_no_early_digit: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid)
    else $error("digit offered right after input transfer");

  // digits of one number follow without a gap in valid
  a_digits_continue: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_digit |=> out_valid)
    else $error("output stopped before last digit");

  // the last digit frees the block
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_digit |=> in_ready && !out_valid)
    else $error("block not idle after last digit");
`endif

endmodule
